// ===== hw/rtl/pclm_pkg.sv =====
// ----------------------------------------------------------------------------
// pclm_pkg
// shared types and constants for the per-core load meter
// ----------------------------------------------------------------------------
`default_nettype none

package pclm_pkg;

   localparam int CORES_DEFAULT   = 16;
   localparam int COUNT_W         = 64;
   localparam int INTERVAL_W      = 16;
   localparam int LOAD_W          = 7;
   localparam int CORE_W          = 4;
   localparam int NUM_W           = COUNT_W + LOAD_W;
   localparam int MOD_BITS_STEP   = 4;
   localparam int MOD_STEPS       = COUNT_W / MOD_BITS_STEP;
   localparam int MOD_CNT_W       = $clog2(MOD_STEPS);
   localparam int DIV_CNT_W       = $clog2(LOAD_W);

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);
   localparam logic [LOAD_W-1:0]     LOAD_SCALE     = LOAD_W'(100);

   typedef struct packed {
      logic [CORE_W-1:0] core_index;
      logic              busy_req;
   } req_type;

   typedef struct packed {
      logic [CORE_W-1:0]  core_index_out;
      logic [COUNT_W-1:0] tick_count;
      logic               load_valid;
      logic [LOAD_W-1:0]  load_percent;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] ticks;
      logic [COUNT_W-1:0] ticks_at_sample;
      logic [COUNT_W-1:0] busy_ticks;
      logic [COUNT_W-1:0] busy_at_sample;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_MOD,
      ST_DIFF,
      ST_SCALE,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/per_core_load_meter.sv =====
// A tick reads its core's row, bumps the counts and reduces the tick count
// modulo the interval at 4 bits a step; a due sample takes the differences,
// scales them and divides, skipped on saturation or an empty period; an
// interval of 0 skips the remainder. One tick at a time: the next tick is
// taken once the previous one is written back, after any output stall.
// Reset: synchronous; all per-core counts read as zero, interval is 100.
// ----------------------------------------------------------------------------
// per_core_load_meter
// per-core tick and busy counters with periodic load sampling in percent
// ----------------------------------------------------------------------------
`default_nettype none

module per_core_load_meter #(
   parameter int CORES = pclm_pkg::CORES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire pclm_pkg::req_type                  req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output pclm_pkg::rsp_type                       rsp_payload,
   input  wire logic                               csr_wr_en,
   input  wire logic [pclm_pkg::INTERVAL_W-1:0]    csr_wr_data
);
   import pclm_pkg::*;

   localparam int AW = (CORES > 1) ? $clog2(CORES) : 1;

   state_type              state_ff, state_in;
   logic [INTERVAL_W-1:0]  interval_ff;
   logic [CORE_W-1:0]      core_ff, core_in;
   logic                   busy_ff, busy_in;
   row_type                row_ff, row_in;
   logic [COUNT_W-1:0]     mod_src_ff, mod_src_in;
   logic [INTERVAL_W-1:0]  mod_rem_ff, mod_rem_in;
   logic [MOD_CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic [COUNT_W-1:0]     part_ff, part_in;
   logic [COUNT_W-1:0]     whole_ff, whole_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [NUM_W-1:0]       den_ff, den_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [LOAD_W-1:0]      q_ff, q_in;
   logic                   sample_ff, sample_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   row_type                mem [CORES];
   logic [CORES-1:0]       vld_ff;
   row_type                rd_row_ff;
   logic                   rd_vld_ff;
   logic                   mem_we;
   logic [AW-1:0]          addr;
   logic                   in_range;

   assign addr      = AW'(core_ff);
   assign in_range  = {5'd0, req_payload.core_index} < 9'(CORES);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // row storage, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= row_ff;
      end
      rd_row_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      core_ff    <= core_in;
      busy_ff    <= busy_in;
      row_ff     <= row_in;
      mod_src_ff <= mod_src_in;
      mod_rem_ff <= mod_rem_in;
      mod_cnt_ff <= mod_cnt_in;
      part_ff    <= part_in;
      whole_ff   <= whole_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      div_cnt_ff <= div_cnt_in;
      q_ff       <= q_in;
      sample_ff  <= sample_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      logic [INTERVAL_W:0]   r;
      logic [INTERVAL_W-1:0] rem;
      row_type               cur;

      state_in     = state_ff;
      core_in      = core_ff;
      busy_in      = busy_ff;
      row_in       = row_ff;
      mod_src_in   = mod_src_ff;
      mod_rem_in   = mod_rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      part_in      = part_ff;
      whole_in     = whole_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      div_cnt_in   = div_cnt_ff;
      q_in         = q_ff;
      sample_in    = sample_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      cur          = rd_vld_ff ? rd_row_ff : '0;

      // interval remainder, a few bits per cycle
      rem = mod_rem_ff;
      for (int i = 0; i < MOD_BITS_STEP; i++) begin
         r = {rem, mod_src_ff[COUNT_W-1-i]};
         if (r >= {1'b0, interval_ff}) begin
            r = r - {1'b0, interval_ff};
         end
         rem = r[INTERVAL_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && in_range) begin
               core_in  = req_payload.core_index;
               busy_in  = req_payload.busy_req;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            row_in            = cur;
            row_in.ticks      = cur.ticks + COUNT_W'(1);
            row_in.busy_ticks = cur.busy_ticks + COUNT_W'(busy_ff);
            mod_src_in        = cur.ticks + COUNT_W'(1);
            mod_rem_in        = '0;
            mod_cnt_in        = '0;
            sample_in         = 1'b0;
            q_in              = '0;
            state_in          = (interval_ff == '0) ? ST_FINISH : ST_MOD;
         end
         ST_MOD: begin
            mod_rem_in = rem;
            mod_src_in = mod_src_ff << MOD_BITS_STEP;
            mod_cnt_in = mod_cnt_ff + MOD_CNT_W'(1);
            if (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
               state_in = (rem == '0) ? ST_DIFF : ST_FINISH;
            end
         end
         ST_DIFF: begin
            whole_in  = row_ff.ticks - row_ff.ticks_at_sample;
            part_in   = row_ff.busy_ticks - row_ff.busy_at_sample;
            row_in.ticks_at_sample = row_ff.ticks;
            row_in.busy_at_sample  = row_ff.busy_ticks;
            sample_in = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            num_in     = NUM_W'({part_ff, 6'd0}) + NUM_W'({part_ff, 5'd0})
                       + NUM_W'({part_ff, 2'd0});
            den_in     = NUM_W'({whole_ff, 6'd0});
            div_cnt_in = '0;
            q_in       = '0;
            if (whole_ff == '0) begin
               state_in = ST_FINISH;
            end else if (part_ff >= whole_ff) begin
               q_in     = LOAD_SCALE;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (num_ff >= den_ff) begin
               num_in = num_ff - den_ff;
               q_in   = {q_ff[LOAD_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[LOAD_W-2:0], 1'b0};
            end
            den_in     = den_ff >> 1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(LOAD_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.core_index_out = core_ff;
               rsp_in.tick_count     = row_ff.ticks;
               rsp_in.load_valid     = sample_ff;
               rsp_in.load_percent   = sample_ff ? q_ff : '0;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_FINISH && state_in == ST_IDLE) begin
         mem_we = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives timer ticks into the per-core load meter and checks every tick
// report against a local copy of the per-core counters, under random idling
// on both channels, a long output hold-off and several sample intervals
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pclm_pkg::*;

   localparam int CORES            = CORES_DEFAULT;
   localparam int CLOCK_HALF       = 10;
   localparam int RESET_CYCLES     = 12;
   localparam int CONFIG_PAUSE     = 4;
   localparam int END_CYCLES       = 40;
   localparam int HOLD_CYCLES      = 300;
   localparam int TIMEOUT_NS       = 10_000_000;
   localparam int MISMATCH_REPORTS = 10;
   localparam int RANDOM_PHASES    = 5;
   localparam int PHASE_TICKS      = 30;
   localparam int PRESSURE_TICKS   = 12;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_wr_en   = 1'b0;
   logic [INTERVAL_W-1:0] csr_wr_data = '0;

   // per-core counters and sample points as the block should hold them
   logic [COUNT_W-1:0]    ticks_now  [CORES] = '{default: '0};
   logic [COUNT_W-1:0]    ticks_mark [CORES] = '{default: '0};
   logic [COUNT_W-1:0]    busy_now   [CORES] = '{default: '0};
   logic [COUNT_W-1:0]    busy_mark  [CORES] = '{default: '0};
   logic [INTERVAL_W-1:0] interval_now = INTERVAL_RESET;

   rsp_type tick_reports [$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      recv_idle_pct  = 0;
   bit      hold_request   = 1'b0;
   int      hold_left      = 0;

   per_core_load_meter #(
      .CORES(CORES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   initial begin
      #TIMEOUT_NS;
      $display("testbench: done, errors");
      $finish;
   end

   // receiver side: random stall, or a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic rsp_type account_tick(req_type item);
      rsp_type            report;
      logic [COUNT_W-1:0] period;
      logic [COUNT_W-1:0] busy_part;
      logic [NUM_W-1:0]   scaled;
      int                 c;
      c = item.core_index;
      report = '0;
      ticks_now[c] = ticks_now[c] + 1'b1;
      if (item.busy_req) begin
         busy_now[c] = busy_now[c] + 1'b1;
      end
      if (interval_now != 0 && (ticks_now[c] % interval_now) == 0) begin
         period = ticks_now[c] - ticks_mark[c];
         busy_part = busy_now[c] - busy_mark[c];
         report.load_valid = 1'b1;
         if (period == 0) begin
            report.load_percent = '0;
         end else if (busy_part >= period) begin
            report.load_percent = LOAD_SCALE;
         end else begin
            scaled = NUM_W'(busy_part) * NUM_W'(LOAD_SCALE) / NUM_W'(period);
            report.load_percent = scaled[LOAD_W-1:0];
         end
         ticks_mark[c] = ticks_now[c];
         busy_mark[c] = busy_now[c];
      end
      report.core_index_out = item.core_index;
      report.tick_count = ticks_now[c];
      return report;
   endfunction

   task automatic send_tick(input logic [CORE_W-1:0] core, input logic busy);
      req_type item;
      item.core_index = core;
      item.busy_req = busy;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_reports.push_back(account_tick(item));
   endtask

   task automatic set_interval(input logic [INTERVAL_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tick_reports.size() != 0) @(posedge clock);
      repeat (CONFIG_PAUSE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      interval_now = value;
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // reset interval, no sample yet
      send_tick(4'd0, 1'b1);
      send_tick(4'd15, 1'b0);
      send_tick(4'd7, 1'b1);
      // every tick samples
      set_interval(16'd1);
      send_tick(4'd0, 1'b1);
      send_tick(4'd0, 1'b0);
      send_tick(4'd15, 1'b1);
      // fractional load and saturation at full busy
      set_interval(16'd3);
      send_tick(4'd5, 1'b1);
      send_tick(4'd5, 1'b0);
      send_tick(4'd5, 1'b0);
      send_tick(4'd5, 1'b1);
      send_tick(4'd5, 1'b1);
      send_tick(4'd5, 1'b1);
      // zero interval never samples
      set_interval(16'd0);
      send_tick(4'd1, 1'b1);
      send_tick(4'd1, 1'b0);
      send_tick(4'd1, 1'b1);
      set_interval(16'hFFFF);
      send_tick(4'd2, 1'b1);
      send_tick(4'd2, 1'b0);
      set_interval(16'd2);
      send_tick(4'd3, 1'b1);
      send_tick(4'd3, 1'b0);
      send_tick(4'd3, 1'b0);
      send_tick(4'd3, 1'b0);
   endtask

   task automatic test_random();
      int                    phase;
      int                    n;
      int                    busy_pct;
      logic [CORE_W-1:0]     hot0;
      logic [CORE_W-1:0]     hot1;
      logic [CORE_W-1:0]     core;
      logic [INTERVAL_W-1:0] value;
      for (int profile = 0; profile < 3; profile++) begin
         send_idle_pct = (profile == 0) ? 7 : (profile == 1) ? 73 : 0;
         recv_idle_pct = (profile == 0) ? 73 : (profile == 1) ? 7 : 0;
         for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(4))
               0: value = 16'd1;
               1: value = INTERVAL_W'($urandom_range(2, 4));
               2: value = INTERVAL_W'($urandom_range(5, 16));
               3: value = INTERVAL_W'($urandom_range(17, 40));
               default: value = INTERVAL_RESET;
            endcase
            set_interval(value);
            busy_pct = $urandom_range(100);
            hot0 = CORE_W'($urandom_range(CORES - 1));
            hot1 = CORE_W'($urandom_range(CORES - 1));
            for (n = 0; n < PHASE_TICKS; n++) begin
               case ($urandom_range(3))
                  0: core = hot0;
                  1, 2: core = hot1;
                  default: core = CORE_W'($urandom_range(CORES - 1));
               endcase
               send_tick(core, $urandom_range(99) < busy_pct);
            end
         end
      end
   endtask

   task automatic test_backpressure();
      logic [CORE_W-1:0] core;
      set_interval(16'd4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      core = CORE_W'($urandom_range(CORES - 1));
      hold_request = 1'b1;
      @(posedge clock);
      repeat (PRESSURE_TICKS) send_tick(core, 1'(($urandom_range(1))));
   endtask

   // result side: each transfer against the oldest pending report
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tick_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS) begin
               $display("%t unexpected transfer: core %0d ticks %0d load %b/%0d",
                        $time, rsp_payload.core_index_out, rsp_payload.tick_count,
                        rsp_payload.load_valid, rsp_payload.load_percent);
            end
         end else begin
            want = tick_reports.pop_front();
            if (rsp_payload.core_index_out !== want.core_index_out ||
                rsp_payload.tick_count !== want.tick_count ||
                rsp_payload.load_valid !== want.load_valid ||
                rsp_payload.load_percent !== want.load_percent) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_REPORTS) begin
                  $display("%t mismatch: expected core %0d ticks %0d load %b/%0d",
                           $time, want.core_index_out, want.tick_count,
                           want.load_valid, want.load_percent);
                  $display("%t           got      core %0d ticks %0d load %b/%0d",
                           $time, rsp_payload.core_index_out, rsp_payload.tick_count,
                           rsp_payload.load_valid, rsp_payload.load_percent);
               end
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tick_reports.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
